// ===== rtl/sfcc_pkg.sv =====
// Shared types, constants and helper functions for the space-filling curve compare block.
`default_nettype none

package sfcc_pkg;

    // Sizing
    localparam int MAX_DIMS   = 16;
    localparam int COORD_BITS = 32;

    localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W     = $clog2(MAX_DIMS + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int PLANE_W   = $clog2(COORD_BITS);
    localparam int LOG_DIMS  = $clog2(MAX_DIMS);

    // Low bit of the coordinate width, folded into the Hilbert direction test
    localparam logic COORD_PAR = 1'(COORD_BITS % 2);

    // Result codes
    localparam logic [1:0] ORDER_LESS    = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    // One bit per dimension, taken from one bit plane
    typedef logic [MAX_DIMS-1:0] plane_t;

    typedef struct packed {
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic        last_coordinate;
    } in_item_t;

    typedef struct packed {
        logic [1:0] order_result;
        logic       too_many_dims;
    } out_item_t;

    // Sequencer to compare unit
    typedef struct packed {
        logic             start;
        logic             step;
        logic             hilbert;
        logic [CNT_W-1:0] n;
    } cmp_ctrl_t;

    // Compare unit to sequencer
    typedef struct packed {
        logic       done;
        logic [1:0] order;
    } cmp_status_t;

    // Mask with the low n bits set
    function automatic plane_t low_ones(input logic [CNT_W-1:0] n);
        plane_t m;
        m = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

    // Rotate right by r inside an n-bit field
    function automatic plane_t rot_right(input plane_t v, input logic [CNT_W-1:0] r,
                                         input logic [CNT_W-1:0] n);
        plane_t m;
        plane_t x;
        m = low_ones(n);
        x = v & m;
        return ((x >> r) | (x << (n - r))) & m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sfcc_plane_store.sv =====
// Coordinate registers for both points; shift left one bit plane per compare step.
`default_nettype none

module sfcc_plane_store
(
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [sfcc_pkg::DIM_IDX_W-1:0]  wr_idx,
    input  wire logic [sfcc_pkg::COORD_BITS-1:0] wr_a,
    input  wire logic [sfcc_pkg::COORD_BITS-1:0] wr_b,
    input  wire logic                            shift,
    output sfcc_pkg::plane_t                     plane_a,
    output sfcc_pkg::plane_t                     plane_b
);

    logic [sfcc_pkg::COORD_BITS-1:0] coord_a_reg [sfcc_pkg::MAX_DIMS];
    logic [sfcc_pkg::COORD_BITS-1:0] coord_b_reg [sfcc_pkg::MAX_DIMS];

    // Load one dimension, or advance every lane to the next plane
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < sfcc_pkg::MAX_DIMS; d++)
        begin
            if (wr_en && (wr_idx == sfcc_pkg::DIM_IDX_W'(d)))
            begin
                coord_a_reg[d] <= wr_a;
                coord_b_reg[d] <= wr_b;
            end
            else if (shift)
            begin
                coord_a_reg[d] <= {coord_a_reg[d][sfcc_pkg::COORD_BITS-2:0], 1'b0};
                coord_b_reg[d] <= {coord_b_reg[d][sfcc_pkg::COORD_BITS-2:0], 1'b0};
            end
        end
    end

    // Current plane is the top bit of each lane
    always_comb
    begin
        for (int d = 0; d < sfcc_pkg::MAX_DIMS; d++)
        begin
            plane_a[d] = coord_a_reg[d][sfcc_pkg::COORD_BITS-1];
            plane_b[d] = coord_b_reg[d][sfcc_pkg::COORD_BITS-1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfcc_cmp_unit.sv =====
// Shared compare unit: evaluates one bit plane per step in Hilbert or Z-order mode.
`default_nettype none

module sfcc_cmp_unit
(
    input  wire logic                  clk,
    input  wire sfcc_pkg::cmp_ctrl_t   ctrl,
    input  wire sfcc_pkg::plane_t      plane_a,
    input  wire sfcc_pkg::plane_t      plane_b,
    output sfcc_pkg::cmp_status_t      status
);

    logic [sfcc_pkg::CNT_W-1:0]   n_reg;
    logic [sfcc_pkg::CNT_W-1:0]   rot_reg;
    logic [sfcc_pkg::CNT_W-1:0]   rot_next;
    logic [sfcc_pkg::PLANE_W-1:0] y_reg;
    sfcc_pkg::plane_t             bits_reg;
    sfcc_pkg::plane_t             bits_next;
    sfcc_pkg::plane_t             index_reg;
    sfcc_pkg::plane_t             index_next;

    sfcc_pkg::plane_t             mask;
    sfcc_pkg::plane_t             pa_m;
    sfcc_pkg::plane_t             pb_m;
    sfcc_pkg::plane_t             diff;
    sfcc_pkg::plane_t             bits_x;
    sfcc_pkg::plane_t             diff_r;
    sfcc_pkg::plane_t             idx_p;
    sfcc_pkg::plane_t             bits_p;
    sfcc_pkg::plane_t             diff_p;
    sfcc_pkg::plane_t             iso_z;
    sfcc_pkg::plane_t             low;
    logic [sfcc_pkg::CNT_W-1:0]   pos;
    logic [sfcc_pkg::SUM_W-1:0]   rot_sum;
    logic                         h_less;
    logic                         z_greater;

    // Plane evaluation
    always_comb
    begin
        mask   = sfcc_pkg::low_ones(n_reg);
        pa_m   = plane_a & mask;
        pb_m   = plane_b & mask;
        diff   = pa_m ^ pb_m;
        bits_x = sfcc_pkg::rot_right(bits_reg ^ pa_m, rot_reg, n_reg);
        diff_r = sfcc_pkg::rot_right(diff, rot_reg, n_reg);

        // Prefix parity toward the low end
        idx_p  = index_reg;
        bits_p = bits_x;
        diff_p = diff_r;
        for (int k = 0; k < sfcc_pkg::LOG_DIMS; k++)
        begin
            idx_p  = idx_p ^ (idx_p >> (1 << k));
            bits_p = bits_p ^ (bits_p >> (1 << k));
            diff_p = diff_p ^ (diff_p >> (1 << k));
        end
        h_less = ((idx_p[0] ^ y_reg[0] ^ sfcc_pkg::COORD_PAR) == (bits_p < (bits_p ^ diff_p)));

        // Z-order: lowest differing dimension decides
        iso_z     = diff & (~diff + sfcc_pkg::plane_t'(1));
        z_greater = |(pa_m & iso_z);

        // Hilbert state update for a plane with no difference
        index_next = index_reg ^ bits_x;
        bits_next  = pa_m ^ (sfcc_pkg::plane_t'(1) << rot_reg);
        low        = bits_x & (~bits_x + sfcc_pkg::plane_t'(1)) & (mask >> 1);
        pos        = '0;
        for (int i = 0; i < sfcc_pkg::MAX_DIMS; i++)
        begin
            if (low[i])
            begin
                pos = pos | sfcc_pkg::CNT_W'(i);
            end
        end
        rot_sum = sfcc_pkg::SUM_W'(rot_reg) + sfcc_pkg::SUM_W'(1)
                + ((low != '0) ? (sfcc_pkg::SUM_W'(pos) + sfcc_pkg::SUM_W'(1))
                               : sfcc_pkg::SUM_W'(0));
        if (rot_sum >= sfcc_pkg::SUM_W'(n_reg))
        begin
            rot_sum = rot_sum - sfcc_pkg::SUM_W'(n_reg);
        end
        rot_next = rot_sum[sfcc_pkg::CNT_W-1:0];

        // Report
        status.done = (diff != '0) || (y_reg == '0);
        if (diff == '0)
        begin
            status.order = sfcc_pkg::ORDER_EQUAL;
        end
        else if (ctrl.hilbert)
        begin
            status.order = h_less ? sfcc_pkg::ORDER_LESS : sfcc_pkg::ORDER_GREATER;
        end
        else
        begin
            status.order = z_greater ? sfcc_pkg::ORDER_GREATER : sfcc_pkg::ORDER_LESS;
        end
    end

    // Seed on start, advance one plane per step
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            n_reg     <= ctrl.n;
            rot_reg   <= '0;
            y_reg     <= sfcc_pkg::PLANE_W'(sfcc_pkg::COORD_BITS - 1);
            bits_reg  <= sfcc_pkg::plane_t'(1) << (ctrl.n - sfcc_pkg::CNT_W'(1));
            index_reg <= sfcc_pkg::plane_t'(1) << (ctrl.n - sfcc_pkg::CNT_W'(1));
        end
        else if (ctrl.step)
        begin
            rot_reg   <= rot_next;
            y_reg     <= y_reg - sfcc_pkg::PLANE_W'(1);
            bits_reg  <= bits_next;
            index_reg <= index_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/space_filling_curve_compare.sv =====
// Top level: item loading, compare sequencer, result register and configuration register.
// Loading: coordinate items are accepted while the sequencer is idle and held off during a compare.
// Compare: after the last item, one bit plane per cycle through the shared compare unit while the
//   result is free; stops at the first differing or last plane; the result registers with that plane.
// A new point pair loads only once the previous compare has finished; a held result stalls each plane.
// Reset clears control state and sets curve_reg to Hilbert; coordinates are not cleared.
`default_nettype none

module space_filling_curve_compare
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire sfcc_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output sfcc_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CMP  = 2'b10
    } seq_state_t;

    seq_state_t                 state_reg;
    seq_state_t                 state_next;
    logic [sfcc_pkg::CNT_W-1:0] count_reg;
    logic                       ovf_reg;
    logic                       curve_reg;
    logic                       out_valid_reg;
    sfcc_pkg::out_item_t        out_data_reg;

    logic                       in_accept;
    logic                       room;
    logic                       out_free;
    logic                       finish;
    logic [sfcc_pkg::CNT_W-1:0] n_load;
    sfcc_pkg::cmp_ctrl_t        ctrl;
    sfcc_pkg::cmp_status_t      status;
    sfcc_pkg::plane_t           plane_a;
    sfcc_pkg::plane_t           plane_b;

    // Handshake and sequencing controls
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        in_accept    = in_valid && !in_stall;
        room         = (count_reg < sfcc_pkg::CNT_W'(sfcc_pkg::MAX_DIMS));
        n_load       = room ? (count_reg + sfcc_pkg::CNT_W'(1)) : count_reg;
        out_free     = !out_valid_reg || !out_stall;
        ctrl.start   = in_accept && in_data.last_coordinate;
        ctrl.step    = (state_reg == ST_CMP) && out_free;
        ctrl.hilbert = curve_reg;
        ctrl.n       = n_load;
        finish       = ctrl.step && status.done;
        out_valid    = out_valid_reg;
        out_data     = out_data_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            curve_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Track stored dimensions and dropped coordinates
            if (finish)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (in_accept)
            begin
                if (room)
                begin
                    count_reg <= n_load;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            // Hold curve selection
            if (cfg_we)
            begin
                curve_reg <= cfg_wdata;
            end

            // Raise result on finish, drop it once taken
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg.order_result  <= status.order;
            out_data_reg.too_many_dims <= ovf_reg;
        end
    end

    sfcc_plane_store u_store
    (
        .clk     (clk),
        .wr_en   (in_accept && room),
        .wr_idx  (count_reg[sfcc_pkg::DIM_IDX_W-1:0]),
        .wr_a    (in_data.value_a[sfcc_pkg::COORD_BITS-1:0]),
        .wr_b    (in_data.value_b[sfcc_pkg::COORD_BITS-1:0]),
        .shift   (ctrl.step),
        .plane_a (plane_a),
        .plane_b (plane_b)
    );

    sfcc_cmp_unit u_cmp
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .plane_a (plane_a),
        .plane_b (plane_b),
        .status  (status)
    );

endmodule

`default_nettype wire
